>>> rtl/mpbm_pkg.sv
// Shared constants, operation codes and control types of the multi-pattern byte matcher.
package mpbm_pkg;

    // Pattern store geometry
    localparam int PATTERNS = 16;
    localparam int MAX_LEN  = 32;

    // Progress counter and stored length widths
    localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 4;
    localparam int CPOS_W = 5;
    localparam int PLEN_W = 6;
    localparam int BYTE_W = 8;
    localparam int MASK_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_LEN    = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN       = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted input transfer
        logic exec;     // apply the latched operation and load the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } t_stat;

endpackage

>>> rtl/mpbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpbm_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mpbm_ctrl.sv
// Controller: accepts an input transfer, then sequences its execution into the result register.
module mpbm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mpbm_pkg::t_stat i_stat,
    output mpbm_pkg::t_cmd  o_cmd
);

    import mpbm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // Take a transfer only while idle
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Hold until the result register has room
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/mpbm_datapath.sv
// Datapath: pattern stores, per-pattern progress tracking and the result register.
module mpbm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpbm_pkg::t_cmd                i_cmd,
    output mpbm_pkg::t_stat               o_stat,
    input  logic [mpbm_pkg::OP_W-1:0]     i_op,
    input  logic [mpbm_pkg::IDX_W-1:0]    i_pattern_index,
    input  logic [mpbm_pkg::CPOS_W-1:0]   i_char_position,
    input  logic [mpbm_pkg::PLEN_W-1:0]   i_pattern_length,
    input  logic [mpbm_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mpbm_pkg::MASK_W-1:0]   o_match_mask,
    output logic                          o_any_match
);

    import mpbm_pkg::*;

    // Latched input transfer
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [CPOS_W-1:0] r_pos;
    logic [PLEN_W-1:0] r_len_in;
    logic [BYTE_W-1:0] r_byte;

    // Per-pattern state
    logic [LEN_W-1:0]  r_len   [PATTERNS];
    logic [POS_W-1:0]  r_prog  [PATTERNS];
    logic [BYTE_W-1:0] r_first [PATTERNS];
    logic [BYTE_W-1:0] rd_byte [PATTERNS];
    logic [POS_W-1:0]  rd_addr [PATTERNS];
    logic [PATTERNS-1:0] done;

    // Result register
    logic              r_out_valid;
    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] mask;

    logic              is_load;
    logic              is_scan;
    logic              pos_ok;
    logic [LEN_W-1:0]  len_sat;

    assign is_load = i_cmd.exec && ((r_op == OP_WRITE_BYTE) || (r_op == OP_SET_LEN));
    assign is_scan = i_cmd.exec && (r_op == OP_SCAN);
    assign pos_ok  = (int'(r_pos) < MAX_LEN);
    assign len_sat = (int'(r_len_in) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(r_len_in);

    // Latch the accepted transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_idx    <= i_pattern_index;
            r_pos    <= i_char_position;
            r_len_in <= i_pattern_length;
            r_byte   <= i_data_byte;
        end
    end

    for (genvar g = 0; g < PATTERNS; g++) begin : g_pat
        logic             sel;
        logic             we;
        logic [LEN_W-1:0] p_ext;
        logic [LEN_W-1:0] np;

        assign sel = (int'(r_idx) == g);
        assign we  = i_cmd.exec && (r_op == OP_WRITE_BYTE) && sel && pos_ok;

        // Read the next expected byte at the current progress
        assign rd_addr[g] = (LEN_W'(r_prog[g]) >= r_len[g]) ? '0 : r_prog[g];

        mpbm_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (MAX_LEN)
        ) u_bytes (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (POS_W'(r_pos)),
            .i_wdata (r_byte),
            .i_raddr (rd_addr[g]),
            .o_rdata (rd_byte[g])
        );

        // Advance, restart or drop progress
        assign p_ext = LEN_W'(rd_addr[g]);
        always_comb begin
            if (r_byte == rd_byte[g]) begin
                np = p_ext + LEN_W'(1);
            end else if (r_byte == r_first[g]) begin
                np = LEN_W'(1);
            end else begin
                np = '0;
            end
        end
        assign done[g] = (r_len[g] != '0) && (np >= r_len[g]);

        // Keep a copy of the first byte for restarts
        always_ff @(posedge i_clk) begin
            if (we && (r_pos == '0)) begin
                r_first[g] <= r_byte;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_len[g]  <= '0;
                r_prog[g] <= '0;
            end else begin
                if (i_cmd.exec && (r_op == OP_SET_LEN) && sel) begin
                    r_len[g] <= len_sat;
                end
                if (is_load) begin
                    r_prog[g] <= '0;
                end else if (is_scan && (r_len[g] != '0)) begin
                    r_prog[g] <= done[g] ? '0 : POS_W'(np);
                end
            end
        end
    end

    // Map completed patterns onto the mask
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < PATTERNS) begin : g_used
            assign mask[b] = done[b];
        end else begin : g_unused
            assign mask[b] = 1'b0;
        end
    end

    // Load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_mask <= (r_op == OP_SCAN) ? mask : '0;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_match_mask    = r_mask;
    assign o_any_match     = (r_mask != '0);

endmodule

>>> rtl/multi_pattern_byte_matcher_top.sv
// A result is registered: the accepted transfer is latched, then executed into the output register
//   once that has room, so a stalled result still holding the output register delays the next one.
// Input is stalled from acceptance until the transfer has executed; each pattern's RAM reads the next expected
//   byte at the stored progress into a register before the compare and update cycle.
// Reset (synchronous, active low): pattern lengths and progress clear, so every pattern
//   is disabled; pattern bytes are kept as they are and need writing before use.
// Input is taken while a finished result still waits in the output register.
module multi_pattern_byte_matcher_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mpbm_pkg::OP_W-1:0]     i_op,
    input  logic [mpbm_pkg::IDX_W-1:0]    i_pattern_index,
    input  logic [mpbm_pkg::CPOS_W-1:0]   i_char_position,
    input  logic [mpbm_pkg::PLEN_W-1:0]   i_pattern_length,
    input  logic [mpbm_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mpbm_pkg::MASK_W-1:0]   o_match_mask,
    output logic                          o_any_match
);

    import mpbm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mpbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mpbm_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_op),
        .i_pattern_index  (i_pattern_index),
        .i_char_position  (i_char_position),
        .i_pattern_length (i_pattern_length),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_mask     (o_match_mask),
        .o_any_match      (o_any_match)
    );

    // A result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // Every execution presents a result next cycle
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_out_valid)
        else $error("execution did not produce a result");

    // An accepted transfer blocks input until it has executed
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // Capture and execution never coincide
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.capture && cmd.exec))
        else $error("capture and execute in the same cycle");

endmodule

>>> sim/multi_pattern_byte_matcher_top_test.sv
// Self-checking testbench for the multi-pattern byte matcher: queued stimulus, clocked driver and checker.
module multi_pattern_byte_matcher_top_test;

    import mpbm_pkg::*;

    // Selector value that the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int TARGET_OPS     = 1700;
    localparam int IDLE_PCT       = 13;
    localparam int QUIET_FROM     = 1200;
    localparam int QUIET_TO       = 2200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [CPOS_W-1:0] pos;
        logic [PLEN_W-1:0] len;
        logic [BYTE_W-1:0] data;
    } t_matcher_op;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              any;
    } t_hit;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op;
    logic [IDX_W-1:0]    i_pattern_index;
    logic [CPOS_W-1:0]   i_char_position;
    logic [PLEN_W-1:0]   i_pattern_length;
    logic [BYTE_W-1:0]   i_data_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [MASK_W-1:0]   o_match_mask;
    logic                o_any_match;

    multi_pattern_byte_matcher_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_pattern_index  (i_pattern_index),
        .i_char_position  (i_char_position),
        .i_pattern_length (i_pattern_length),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_mask     (o_match_mask),
        .o_any_match      (o_any_match)
    );

    // Pending operations and the hits expected from accepted ones
    t_matcher_op pending_ops[$];
    t_hit        expected_hits[$];

    // Predictor state
    logic [BYTE_W-1:0] pat_mem [PATTERNS][MAX_LEN];
    int                pat_len [PATTERNS];
    int                progress[PATTERNS];

    // Generator bookkeeping: which pattern bytes hold known data
    bit                gen_written[PATTERNS][MAX_LEN];
    logic [BYTE_W-1:0] gen_pat    [PATTERNS][MAX_LEN];
    int                gen_len    [PATTERNS];
    logic [BYTE_W-1:0] alpha[4];
    int                alpha_n;
    int                n_items;

    logic        in_fire;
    int          idle_cycles;
    int          cyc;
    int          n_fail;
    bit          send_gap;
    bit          quiet;
    t_matcher_op next_op;
    t_hit        want;
    logic [MASK_W-1:0] hits_now;

    // Work out the hit mask of one accepted operation and update the predictor state
    function automatic logic [MASK_W-1:0] predict_hits(t_matcher_op it);
        logic [MASK_W-1:0] hits;
        int p;
        hits = '0;
        case (it.op)
            OP_WRITE_BYTE: begin
                for (int i = 0; i < PATTERNS; i++) progress[i] = 0;
                if (int'(it.idx) < PATTERNS && int'(it.pos) < MAX_LEN)
                    pat_mem[it.idx][it.pos] = it.data;
            end
            OP_SET_LEN: begin
                for (int i = 0; i < PATTERNS; i++) progress[i] = 0;
                if (int'(it.idx) < PATTERNS)
                    pat_len[it.idx] = (int'(it.len) > MAX_LEN) ? MAX_LEN : int'(it.len);
            end
            OP_SCAN: begin
                for (int i = 0; i < PATTERNS; i++) begin
                    if (pat_len[i] != 0) begin
                        p = progress[i];
                        if (p >= pat_len[i]) p = 0;
                        if (it.data == pat_mem[i][p]) p++;
                        else if (it.data == pat_mem[i][0]) p = 1;
                        else p = 0;
                        if (p >= pat_len[i]) begin
                            if (i < MASK_W) hits[i] = 1'b1;
                            p = 0;
                        end
                        progress[i] = p;
                    end
                end
            end
            default: ;
        endcase
        return hits;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_alpha();
        return alpha[$urandom_range(0, alpha_n - 1)];
    endfunction

    // Mostly short lengths, some long, a few saturating, a few disabling
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 7) return 0;
        if (r < 85) return $urandom_range(1, 6);
        if (r < 95) return $urandom_range(7, MAX_LEN);
        return $urandom_range(MAX_LEN + 1, 63);
    endfunction

    task automatic push_op(logic [OP_W-1:0] op, int idx, int pos, int len, int data);
        t_matcher_op it;
        it.op   = op;
        it.idx  = IDX_W'(idx);
        it.pos  = CPOS_W'(pos);
        it.len  = PLEN_W'(len);
        it.data = BYTE_W'(data);
        pending_ops.push_back(it);
        if (op != OP_UNUSED) n_items++;
        if (op == OP_WRITE_BYTE) begin
            gen_written[idx][pos] = 1'b1;
            gen_pat[idx][pos]     = BYTE_W'(data);
        end
        if (op == OP_SET_LEN) gen_len[idx] = (len > MAX_LEN) ? MAX_LEN : len;
    endtask

    task automatic put_byte(int idx, int pos, int data);
        push_op(OP_WRITE_BYTE, idx, pos, $urandom_range(0, 63), data);
    endtask

    task automatic scan(int data);
        push_op(OP_SCAN, $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 63), data);
    endtask

    // Fill any unwritten byte inside the new length before enabling the pattern
    task automatic set_length(int idx, int len);
        int eff;
        eff = (len > MAX_LEN) ? MAX_LEN : len;
        for (int p = 0; p < eff; p++)
            if (!gen_written[idx][p]) put_byte(idx, p, int'(pick_alpha()));
        push_op(OP_SET_LEN, idx, $urandom_range(0, 31), len, $urandom);
    endtask

    // Scan a full copy of some enabled pattern
    task automatic inject_pattern();
        int start;
        int idx;
        start = $urandom_range(0, PATTERNS - 1);
        for (int k = 0; k < PATTERNS; k++) begin
            idx = (start + k) % PATTERNS;
            if (gen_len[idx] != 0) begin
                for (int p = 0; p < gen_len[idx]; p++) scan(int'(gen_pat[idx][p]));
                return;
            end
        end
    endtask

    task automatic random_round(int round);
        int n_prog;
        int n_scan;
        int idx;
        int len;
        int eff;
        int r;
        alpha_n = $urandom_range(2, 4);
        for (int j = 0; j < 4; j++) alpha[j] = BYTE_W'($urandom);
        n_prog = $urandom_range(1, 4);
        // Program a few patterns over a small alphabet
        for (int k = 0; k < n_prog; k++) begin
            idx = (round == 0 && k == 0) ? 1 : $urandom_range(0, PATTERNS - 1);
            len = (round == 0 && k == 0) ? 63 : pick_length();
            eff = (len > MAX_LEN) ? MAX_LEN : len;
            for (int p = 0; p < eff; p++)
                if ($urandom_range(0, 99) < 80) put_byte(idx, p, int'(pick_alpha()));
            if ($urandom_range(0, 99) < 20)
                put_byte(idx, $urandom_range(0, MAX_LEN - 1), $urandom);
            set_length(idx, len);
        end
        // Stream mostly alphabet bytes with whole patterns mixed in
        n_scan = $urandom_range(20, 60);
        for (int s = 0; s < n_scan; s++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                push_op(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 31),
                        $urandom_range(0, 63), $urandom);
            else if (r < 5) begin
                if ($urandom_range(0, 1))
                    put_byte($urandom_range(0, 15), $urandom_range(0, 31), $urandom);
                else
                    set_length($urandom_range(0, 15), pick_length());
            end
            else if (r < 18) inject_pattern();
            else if (r < 90) scan(int'(pick_alpha()));
            else scan($urandom_range(0, 255));
        end
    endtask

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Build the stimulus, apply reset, wait for the drain and report
    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_out_stall      = 1'b0;
        i_op             = '0;
        i_pattern_index  = '0;
        i_char_position  = '0;
        i_pattern_length = '0;
        i_data_byte      = '0;
        in_fire          = 1'b0;
        idle_cycles      = 0;
        cyc              = 0;
        n_fail           = 0;
        n_items          = 0;
        for (int i = 0; i < PATTERNS; i++) begin
            pat_len[i]  = 0;
            progress[i] = 0;
            gen_len[i]  = 0;
        end
        alpha   = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        alpha_n = 4;

        // Nothing enabled yet, then the unused selector with every field high
        scan('hFF);
        push_op(OP_UNUSED, 15, 31, 63, 'hFF);
        // Pattern 0 = AA AA 55: a third AA must restart progress at one
        put_byte(0, 0, 'hAA);
        put_byte(0, 1, 'hAA);
        put_byte(0, 2, 'h55);
        set_length(0, 3);
        put_byte(15, 0, 'hFF);
        set_length(15, 1);
        scan('hAA);
        scan('hAA);
        scan('hAA);
        scan('h55);
        scan('hFF);
        // Last byte position; the load also clears progress
        put_byte(15, 31, 'h00);
        // Unused selector keeps progress
        scan('hAA);
        scan('hAA);
        push_op(OP_UNUSED, 0, 0, 0, 'h00);
        scan('h55);
        // A load in the middle of a match drops the partial progress
        scan('hAA);
        scan('hAA);
        set_length(15, 1);
        scan('h55);
        // Disable pattern 15
        set_length(15, 0);
        scan('hFF);

        for (int round = 0; n_items < TARGET_OPS; round++) random_round(round);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_in_valid || expected_hits.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_fail == 0 && expected_hits.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Driver: advance to the next operation after a transfer, hold while stalled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            quiet    = (cyc >= QUIET_FROM && cyc < QUIET_TO);
            send_gap = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
            if (!i_in_valid || in_fire) begin
                if (pending_ops.size() != 0 && !send_gap) begin
                    next_op          = pending_ops.pop_front();
                    i_op             <= next_op.op;
                    i_pattern_index  <= next_op.idx;
                    i_char_position  <= next_op.pos;
                    i_pattern_length <= next_op.len;
                    i_data_byte      <= next_op.data;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Monitor: check result transfers, then predict for input transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result: match_mask %h, any_match %b",
                           o_match_mask, o_any_match);
                    n_fail++;
                end else begin
                    want = expected_hits.pop_front();
                    if (o_match_mask !== want.mask) begin
                        $error("match_mask: expected %h, actual %h", want.mask, o_match_mask);
                        n_fail++;
                    end
                    if (o_any_match !== want.any) begin
                        $error("any_match: expected %b, actual %b", want.any, o_any_match);
                        n_fail++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                hits_now = predict_hits({i_op, i_pattern_index, i_char_position,
                                         i_pattern_length, i_data_byte});
                expected_hits.push_back({hits_now, |hits_now});
            end
            in_fire     <= i_in_valid && !o_in_stall;
            idle_cycles <= ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                           ? 0 : idle_cycles + 1;
            cyc         <= cyc + 1;
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
